/* src/hbcd_pkg.sv */
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; imported by every module of the block.
package hbcd_pkg;

    localparam int LINE_CAP_DEF = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BODY_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LENGTH = 1'd1;

    localparam logic [1:0] MODE_CHUNKED = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;

    localparam logic [2:0] PH_SIZE    = 3'd0;
    localparam logic [2:0] PH_DATA    = 3'd1;
    localparam logic [2:0] PH_CR      = 3'd2;
    localparam logic [2:0] PH_LF      = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    localparam logic [31:0] SIZE_SHIFT_MAX = 32'h0fff_ffff;
    localparam logic [2:0]  TRAILER_END    = 3'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] size_accum;
        logic        after_semicolon;
        logic        digit_error;
        logic [31:0] chunk_left;
        logic [2:0]  trailer_match;
        logic        trailer_has_data;
    } t_chk_st;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       status;
        logic       complete;
    } t_result;

    function automatic logic [7:0] end_seq_byte(input logic [1:0] idx);
        logic [7:0] b;
        b = idx[0] ? CH_LF : CH_CR;
        return b;
    endfunction

endpackage

/* src/hbcd_chunk.sv */
// Next-state logic for one chunked-encoding byte: size line, data, CRLF, trailers.
// Depends on hbcd_pkg.
module hbcd_chunk #(
    parameter int LINE_CAP = hbcd_pkg::LINE_CAP_DEF,
    parameter int LC_W     = $clog2(LINE_CAP)
) (
    input  hbcd_pkg::t_chk_st i_st,
    input  logic [LC_W-1:0]   i_line_count,
    input  logic [7:0]        i_byte,
    output hbcd_pkg::t_chk_st o_st,
    output logic [LC_W-1:0]   o_line_count,
    output logic              o_deliver,
    output logic              o_error,
    output logic              o_done
);
    import hbcd_pkg::*;

    localparam logic [LC_W-1:0] LC_MAX = LC_W'(LINE_CAP - 1);

    logic [3:0]  dig;
    logic        dig_ok;
    logic [31:0] left_dec;
    logic [2:0]  tm_new;
    logic        hd_new;

    always_comb begin
        dig    = 4'd0;
        dig_ok = 1'b1;
        case (i_byte) inside
            [8'h30:8'h39]: dig = i_byte[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: dig = i_byte[3:0] + 4'd9;
            default: dig_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_st         = i_st;
        o_line_count = i_line_count;
        o_deliver    = 1'b0;
        o_error      = 1'b0;
        o_done       = 1'b0;
        left_dec     = i_st.chunk_left - 32'd1;
        hd_new       = i_st.trailer_has_data |
                       ((i_st.trailer_match == 3'd0) && (i_byte != CH_CR));
        if (i_byte == end_seq_byte(i_st.trailer_match[1:0])) begin
            tm_new = i_st.trailer_match + 3'd1;
        end else begin
            tm_new = (i_byte == CH_CR) ? 3'd1 : 3'd0;
        end
        case (i_st.phase)
            PH_SIZE: begin
                if (i_byte == CH_CR) begin
                    o_st = i_st;
                end else if (i_byte == CH_LF) begin
                    if (i_line_count == '0 || i_st.digit_error) begin
                        o_error = 1'b1;
                    end else begin
                        o_st.chunk_left      = i_st.size_accum;
                        o_st.phase           = (i_st.size_accum == 32'd0) ? PH_TRAILER : PH_DATA;
                        o_st.size_accum      = 32'd0;
                        o_st.after_semicolon = 1'b0;
                        o_st.digit_error     = 1'b0;
                        o_line_count         = '0;
                    end
                end else if (i_line_count >= LC_MAX) begin
                    o_error = 1'b1;
                end else begin
                    o_line_count = i_line_count + LC_W'(1);
                    if (!i_st.after_semicolon && !i_st.digit_error) begin
                        if (i_byte == CH_SEMI) begin
                            o_st.after_semicolon = 1'b1;
                        end else if (!dig_ok || i_st.size_accum > SIZE_SHIFT_MAX) begin
                            o_st.digit_error = 1'b1;
                        end else begin
                            o_st.size_accum = {i_st.size_accum[27:0], dig};
                        end
                    end
                end
            end
            PH_DATA: begin
                o_deliver = 1'b1;
                if (i_st.chunk_left <= 32'd1) begin
                    o_st.chunk_left = 32'd0;
                    o_st.phase      = PH_CR;
                end else begin
                    o_st.chunk_left = left_dec;
                end
            end
            PH_CR: begin
                if (i_byte != CH_CR) begin
                    o_error = 1'b1;
                end else begin
                    o_st.phase = PH_LF;
                end
            end
            PH_LF: begin
                if (i_byte != CH_LF) begin
                    o_error = 1'b1;
                end else begin
                    o_st.phase = PH_SIZE;
                end
            end
            PH_TRAILER: begin
                o_st.trailer_has_data = hd_new;
                o_st.trailer_match    = tm_new;
                if ((!hd_new && tm_new == 3'd2) || tm_new >= TRAILER_END) begin
                    o_st.phase = PH_DONE;
                    o_done     = 1'b1;
                end
            end
            default: begin
                o_st = i_st;
            end
        endcase
    end

endmodule

/* src/hbcd_out.sv */
// Result register with valid/stall handshake toward the receiver.
// Depends on hbcd_pkg for the result word type.
module hbcd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hbcd_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_busy,
    output logic              o_valid,
    output hbcd_pkg::t_result o_res
);
    import hbcd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_busy  = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* src/http_body_chunked_decoder.sv */
// Top level of the HTTP body decoder: config registers, decode state, result stage.
// Depends on hbcd_pkg, hbcd_chunk and hbcd_out.
//
// Usage:
//   Input channel: i_valid / o_stall with i_mode, i_data_byte. One word is taken
//   per cycle unless stalled; i_mode high ends the connection, runs finish check.
//   Output channel: o_valid / i_stall with o_body_valid, o_body_byte, o_status
//   and o_complete. Every input word yields exactly one output word.
//   Config channel: i_cfg_valid / o_cfg_ready (always high), index 0 selects
//   body_mode, index 1 content_length. Write only while the block is idle.
//   Result is registered, valid the cycle after accept. Throughput: one word per
//   cycle unless stalled, set by the single registered decode step on the bytes.
//   Receiver stall: the result register holds; o_stall rises while a held
//   result is stalled, and a new word is taken in the cycle the result leaves.
//   Reset: synchronous, active low; clears config, decode state and flags,
//   and empties the result register.
module http_body_chunked_decoder #(
    parameter int LINE_CAP = hbcd_pkg::LINE_CAP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_body_valid,
    output logic [7:0]                     o_body_byte,
    output logic                           o_status,
    output logic                           o_complete,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hbcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hbcd_pkg::*;

    localparam int LC_W = $clog2(LINE_CAP);

    logic [1:0]      r_body_mode;
    logic [31:0]     r_content_length;
    t_chk_st         r_chk;
    t_chk_st         n_chk;
    logic [LC_W-1:0] r_line_count;
    logic [LC_W-1:0] n_line_count;
    logic [31:0]     r_body_count;
    logic [31:0]     n_body_count;
    logic            r_error;
    logic            n_error;
    logic            r_done;
    logic            n_done;

    t_chk_st         chk_st;
    logic [LC_W-1:0] chk_lc;
    logic            chk_deliver;
    logic            chk_error;
    logic            chk_done;
    logic            accept;
    logic            out_busy;
    logic            deliver;
    logic            below_len;
    t_result         res;
    t_result         out_res;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = out_busy;
    assign accept      = i_valid & ~out_busy;

    hbcd_chunk #(
        .LINE_CAP (LINE_CAP),
        .LC_W     (LC_W)
    ) u_chunk (
        .i_st         (r_chk),
        .i_line_count (r_line_count),
        .i_byte       (i_data_byte),
        .o_st         (chk_st),
        .o_line_count (chk_lc),
        .o_deliver    (chk_deliver),
        .o_error      (chk_error),
        .o_done       (chk_done)
    );

    assign below_len = r_body_count < r_content_length;

    always_comb begin
        n_chk        = r_chk;
        n_line_count = r_line_count;
        n_body_count = r_body_count;
        n_error      = r_error;
        n_done       = r_done;
        deliver      = 1'b0;
        if (!r_error) begin
            if (i_mode) begin
                if ((r_body_mode == MODE_CHUNKED && r_chk.phase != PH_DONE) ||
                    (r_body_mode == MODE_LENGTH && r_body_count != r_content_length)) begin
                    n_error = 1'b1;
                end else begin
                    n_done = 1'b1;
                end
            end else if (!r_done) begin
                case (r_body_mode)
                    MODE_CHUNKED: begin
                        n_chk        = chk_st;
                        n_line_count = chk_lc;
                        n_error      = chk_error;
                        n_done       = chk_done;
                        deliver      = chk_deliver;
                        if (chk_deliver) begin
                            n_body_count = r_body_count + 32'd1;
                        end
                    end
                    MODE_LENGTH: begin
                        if (below_len) begin
                            n_body_count = r_body_count + 32'd1;
                            deliver      = 1'b1;
                        end
                        n_done = (n_body_count == r_content_length);
                    end
                    default: begin
                        n_body_count = r_body_count + 32'd1;
                        deliver      = 1'b1;
                    end
                endcase
            end
        end
        res.body_valid = deliver;
        res.body_byte  = deliver ? i_data_byte : 8'd0;
        res.status     = n_error;
        res.complete   = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_mode      <= MODE_CHUNKED;
            r_content_length <= 32'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BODY_MODE:      r_body_mode      <= i_cfg_data[1:0];
                CFG_CONTENT_LENGTH: r_content_length <= i_cfg_data[31:0];
                default: begin
                    r_body_mode <= r_body_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk        <= '0;
            r_line_count <= '0;
            r_body_count <= 32'd0;
            r_error      <= 1'b0;
            r_done       <= 1'b0;
        end else if (accept) begin
            r_chk        <= n_chk;
            r_line_count <= n_line_count;
            r_body_count <= n_body_count;
            r_error      <= n_error;
            r_done       <= n_done;
        end
    end

    hbcd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_res   (res),
        .i_stall (i_stall),
        .o_busy  (out_busy),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_body_valid = out_res.body_valid;
    assign o_body_byte  = out_res.body_byte;
    assign o_status     = out_res.status;
    assign o_complete   = out_res.complete;

endmodule
